>>> hw/rtl/tbpc_pkg.sv
`timescale 1ns / 1ps

package tbpc_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int IDX_W   = 2;

    localparam logic [1:0] KIND_SHORT = 2'd0;
    localparam logic [1:0] KIND_LONG  = 2'd1;
    localparam logic [1:0] KIND_COMBO = 2'd2;

    localparam logic [1:0] BTN_UP     = 2'd0;
    localparam logic [1:0] BTN_ACTION = 2'd1;
    localparam logic [1:0] BTN_DOWN   = 2'd2;

    localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [IDX_W-1:0] REG_LONG     = 2'd1;
    localparam logic [IDX_W-1:0] REG_COMBO    = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;
    localparam logic [CFG_W-1:0] COMBO_RST    = 16'd2000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] long_press_time;
        logic [CFG_W-1:0] combo_hold_time;
    } cfg_t;

    typedef struct packed {
        logic              ev;
        logic [1:0]        kind;
        logic              stable;
        logic [TIME_W-1:0] press_start;
    } btn_stat_t;

endpackage

>>> hw/rtl/tbpc_if.sv
`timescale 1ns / 1ps

interface tbpc_sample_if;
    logic                         valid;
    logic                         ready;
    logic                         up_level;
    logic                         action_level;
    logic                         down_level;
    logic [tbpc_pkg::TIME_W-1:0]  time_now;

    modport source (output valid, output up_level, output action_level,
                    output down_level, output time_now, input ready);
    modport sink   (input valid, input up_level, input action_level,
                    input down_level, input time_now, output ready);
endinterface

interface tbpc_report_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [1:0] button_code;

    modport source (output valid, output event_kind, output button_code, input ready);
    modport sink   (input valid, input event_kind, input button_code, output ready);
endinterface

>>> hw/rtl/tbpc_cfg_regs.sv
`timescale 1ns / 1ps

module tbpc_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbpc_pkg::PADDR_W-1:0]  paddr,
    input  logic [tbpc_pkg::PDATA_W-1:0]  pwdata,
    output logic [tbpc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output tbpc_pkg::cfg_t                cfg
);

    tbpc_pkg::cfg_t                  cfg_reg;
    logic                            wr_en;
    logic [tbpc_pkg::IDX_W-1:0]      idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[tbpc_pkg::PADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time   <= tbpc_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_time <= tbpc_pkg::LONG_RST;
            cfg_reg.combo_hold_time <= tbpc_pkg::COMBO_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                tbpc_pkg::REG_DEBOUNCE:
                    cfg_reg.debounce_time <= pwdata[tbpc_pkg::CFG_W-1:0];
                tbpc_pkg::REG_LONG:
                    cfg_reg.long_press_time <= pwdata[tbpc_pkg::CFG_W-1:0];
                tbpc_pkg::REG_COMBO:
                    cfg_reg.combo_hold_time <= pwdata[tbpc_pkg::CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            tbpc_pkg::REG_DEBOUNCE:
                prdata[tbpc_pkg::CFG_W-1:0] = cfg_reg.debounce_time;
            tbpc_pkg::REG_LONG:
                prdata[tbpc_pkg::CFG_W-1:0] = cfg_reg.long_press_time;
            tbpc_pkg::REG_COMBO:
                prdata[tbpc_pkg::CFG_W-1:0] = cfg_reg.combo_hold_time;
            default:
                prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/tbpc_button.sv
`timescale 1ns / 1ps

module tbpc_button
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         long_en,
    input  logic                         raw,
    input  logic [tbpc_pkg::TIME_W-1:0]  now,
    input  logic [tbpc_pkg::CFG_W-1:0]   debounce_time,
    input  logic [tbpc_pkg::CFG_W-1:0]   long_press_time,
    output tbpc_pkg::btn_stat_t          stat
);

    logic                         last_raw_reg;
    logic                         last_raw_next;
    logic [tbpc_pkg::TIME_W-1:0]  change_time_reg;
    logic [tbpc_pkg::TIME_W-1:0]  change_time_next;
    logic                         stable_reg;
    logic                         stable_next;
    logic [tbpc_pkg::TIME_W-1:0]  start_reg;
    logic [tbpc_pkg::TIME_W-1:0]  start_next;
    logic                         held_reg;
    logic                         held_next;

    logic                         changed;
    logic [tbpc_pkg::TIME_W-1:0]  deb_elapsed;
    logic [tbpc_pkg::TIME_W-1:0]  hold_elapsed;
    logic                         take;
    logic                         held_mid;
    logic                         short_ev;
    logic                         long_ev;

    always_comb
    begin
        changed          = raw != last_raw_reg;
        last_raw_next    = raw;
        change_time_next = changed ? now : change_time_reg;
        deb_elapsed      = now - change_time_next;
        take             = (deb_elapsed >= tbpc_pkg::TIME_W'(debounce_time))
                           && (raw != stable_reg);
        stable_next      = take ? raw : stable_reg;
        start_next       = (take && raw) ? now : start_reg;
        held_mid         = (take && raw) ? 1'b0 : held_reg;
        short_ev         = take && !raw && !held_reg;
        hold_elapsed     = now - start_next;
        long_ev          = long_en && !short_ev && stable_next && !held_mid
                           && (hold_elapsed >= tbpc_pkg::TIME_W'(long_press_time));
        held_next        = held_mid || long_ev;

        stat.ev          = short_ev || long_ev;
        stat.kind        = long_ev ? tbpc_pkg::KIND_LONG : tbpc_pkg::KIND_SHORT;
        stat.stable      = stable_next;
        stat.press_start = start_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg    <= 1'b0;
            change_time_reg <= '0;
            stable_reg      <= 1'b0;
            start_reg       <= '0;
            held_reg        <= 1'b0;
        end
        else if (step)
        begin
            last_raw_reg    <= last_raw_next;
            change_time_reg <= change_time_next;
            stable_reg      <= stable_next;
            start_reg       <= start_next;
            held_reg        <= held_next;
        end
    end

endmodule

>>> hw/rtl/tbpc_combo.sv
`timescale 1ns / 1ps

module tbpc_combo
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [tbpc_pkg::TIME_W-1:0]  now,
    input  logic [tbpc_pkg::CFG_W-1:0]   combo_hold_time,
    input  tbpc_pkg::btn_stat_t          up_stat,
    input  tbpc_pkg::btn_stat_t          down_stat,
    output logic                         ev
);

    logic                         reported_reg;
    logic                         reported_next;
    logic                         both;
    logic [tbpc_pkg::TIME_W-1:0]  start;
    logic [tbpc_pkg::TIME_W-1:0]  elapsed;

    always_comb
    begin
        both          = up_stat.stable && down_stat.stable;
        start         = (up_stat.press_start > down_stat.press_start)
                        ? up_stat.press_start : down_stat.press_start;
        elapsed       = now - start;
        ev            = both && !reported_reg
                        && (elapsed >= tbpc_pkg::TIME_W'(combo_hold_time));
        reported_next = both && (reported_reg || ev);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg <= 1'b0;
        end
        else if (step)
        begin
            reported_reg <= reported_next;
        end
    end

endmodule

>>> hw/rtl/three_button_press_classifier.sv
`timescale 1ns / 1ps

// channel  | dir | beat fields
// ---------+-----+------------------------------------------------------
// sample   | in  | up_level, action_level, down_level, time_now[31:0]
// report   | out | event_kind[1:0], button_code[1:0]
// apb      | cfg | 0x0 debounce_time, 0x4 long_press_time, 0x8 combo_hold_time
//
// One sample beat per cycle while the report is not stalled; a sample passes the
// sample register, then the report register, and gives a report only on an event.
// The button/combo update between those two registers is combinational.
// Reset: all button state clears to released, time stamps to zero.
// A stalled report holds the sample stage; sample.ready drops only then.
module three_button_press_classifier
(
    input  logic                          clk,
    input  logic                          rst_n,
    tbpc_sample_if.sink                   sample,
    tbpc_report_if.source                 report,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbpc_pkg::PADDR_W-1:0]  paddr,
    input  logic [tbpc_pkg::PDATA_W-1:0]  pwdata,
    output logic [tbpc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    tbpc_pkg::cfg_t               cfg;

    logic                         in_valid_reg;
    logic                         up_reg;
    logic                         action_reg;
    logic                         down_reg;
    logic [tbpc_pkg::TIME_W-1:0]  now_reg;

    logic                         out_valid_reg;
    logic [1:0]                   kind_reg;
    logic [1:0]                   kind_next;
    logic [1:0]                   code_reg;
    logic [1:0]                   code_next;

    logic                         go;
    logic                         any_ev;
    logic                         combo_ev;
    tbpc_pkg::btn_stat_t          up_stat;
    tbpc_pkg::btn_stat_t          action_stat;
    tbpc_pkg::btn_stat_t          down_stat;

    assign go           = in_valid_reg && (!out_valid_reg || report.ready);
    assign sample.ready = !in_valid_reg || go;

    tbpc_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbpc_button u_up
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (go),
        .long_en         (1'b0),
        .raw             (up_reg),
        .now             (now_reg),
        .debounce_time   (cfg.debounce_time),
        .long_press_time (cfg.long_press_time),
        .stat            (up_stat)
    );

    tbpc_button u_action
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (go && !up_stat.ev),
        .long_en         (1'b1),
        .raw             (action_reg),
        .now             (now_reg),
        .debounce_time   (cfg.debounce_time),
        .long_press_time (cfg.long_press_time),
        .stat            (action_stat)
    );

    tbpc_button u_down
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (go && !up_stat.ev && !action_stat.ev),
        .long_en         (1'b0),
        .raw             (down_reg),
        .now             (now_reg),
        .debounce_time   (cfg.debounce_time),
        .long_press_time (cfg.long_press_time),
        .stat            (down_stat)
    );

    tbpc_combo u_combo
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (go && !up_stat.ev && !action_stat.ev && !down_stat.ev),
        .now             (now_reg),
        .combo_hold_time (cfg.combo_hold_time),
        .up_stat         (up_stat),
        .down_stat       (down_stat),
        .ev              (combo_ev)
    );

    // first event in up, action, down, combo order wins
    always_comb
    begin
        any_ev    = up_stat.ev || action_stat.ev || down_stat.ev || combo_ev;
        kind_next = tbpc_pkg::KIND_COMBO;
        code_next = tbpc_pkg::BTN_ACTION;
        if (up_stat.ev)
        begin
            kind_next = up_stat.kind;
            code_next = tbpc_pkg::BTN_UP;
        end
        else if (action_stat.ev)
        begin
            kind_next = action_stat.kind;
            code_next = tbpc_pkg::BTN_ACTION;
        end
        else if (down_stat.ev)
        begin
            kind_next = down_stat.kind;
            code_next = tbpc_pkg::BTN_DOWN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (go)
            begin
                out_valid_reg <= any_ev;
            end
            else if (report.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            up_reg     <= sample.up_level;
            action_reg <= sample.action_level;
            down_reg   <= sample.down_level;
            now_reg    <= sample.time_now;
        end
        if (go && any_ev)
        begin
            kind_reg <= kind_next;
            code_reg <= code_next;
        end
    end

    assign report.valid       = out_valid_reg;
    assign report.event_kind  = kind_reg;
    assign report.button_code = code_reg;

endmodule

>>> hw/rtl/tbpc_checker.sv
`timescale 1ns / 1ps

module tbpc_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       report_valid,
    input  logic       report_ready,
    input  logic [1:0] event_kind,
    input  logic [1:0] button_code
);

    a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready |=>
            report_valid && $stable(event_kind) && $stable(button_code))
        else $error("report beat changed while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> (event_kind == tbpc_pkg::KIND_SHORT
                          || event_kind == tbpc_pkg::KIND_LONG
                          || event_kind == tbpc_pkg::KIND_COMBO))
        else $error("illegal event kind");

    a_long_is_action: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && event_kind == tbpc_pkg::KIND_LONG
            |-> button_code == tbpc_pkg::BTN_ACTION)
        else $error("long press from a button other than action");

    a_combo_code: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && event_kind == tbpc_pkg::KIND_COMBO
            |-> button_code == tbpc_pkg::BTN_ACTION)
        else $error("combo event with wrong button code");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !report_valid)
        else $error("report valid during reset");

endmodule

bind three_button_press_classifier tbpc_checker u_tbpc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .report_valid (report.valid),
    .report_ready (report.ready),
    .event_kind   (report.event_kind),
    .button_code  (report.button_code)
);
